/* hdl/xmodem_crc_frame_receiver_macros.svh */
// Assertion macros for the XMODEM-CRC frame receiver.
`ifndef XMODEM_CRC_FRAME_RECEIVER_MACROS_SVH
`define XMODEM_CRC_FRAME_RECEIVER_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checks that the consequent holds in the same cycle as the antecedent.
`define XCRC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);
// Checks that the consequent holds in the cycle after the antecedent.
`define XCRC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);
`else
`define XCRC_ASSERT_NOW(lbl, ante, cons, msg)
`define XCRC_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

/* hdl/xcrc_pkg.sv */
// Shared constants, types and the CRC function of the XMODEM-CRC frame receiver.
package xcrc_pkg;

  localparam int FRAME_DATA_BYTES = 128;
  localparam int BLOCK_COUNT_BITS = 16;
  localparam int WORDS            = FRAME_DATA_BYTES / 4;
  localparam int WORD_IDX_BITS    = $clog2(WORDS);

  localparam logic [7:0]  FRAME_LEN  = 8'd133;
  localparam logic [7:0]  LEN_SAT    = 8'd134;
  localparam logic [7:0]  DATA_FIRST = 8'd3;
  localparam logic [7:0]  CRC_HI_IDX = 8'd131;
  localparam logic [7:0]  CRC_LO_IDX = 8'd132;
  localparam logic [7:0]  LEAD_SOH   = 8'h01;
  localparam logic [7:0]  LEAD_EOT   = 8'h04;
  localparam logic [15:0] CRC_POLY   = 16'h1021;
  localparam logic [15:0] CRC_INIT   = 16'h0000;
  localparam logic [15:0] CRC_TOP    = 16'h8000;

  typedef enum logic [1:0] {
    REPLY_NONE = 2'd0,
    REPLY_ACK  = 2'd1,
    REPLY_NAK  = 2'd2
  } reply_t;

  typedef enum logic [1:0] {
    CMD_BURST,
    CMD_NAK,
    CMD_EOT
  } cmd_kind_t;

  typedef struct packed {
    cmd_kind_t                   kind;
    logic [BLOCK_COUNT_BITS-1:0] blk;
  } cmd_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_FETCH,
    BK_EMIT
  } back_state_t;

  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      if ((c & CRC_TOP) != 16'h0000) begin
        c = {c[14:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[14:0], 1'b0};
      end
    end
    return c;
  endfunction

endpackage

/* hdl/xmodem_crc_frame_receiver.sv */
// XMODEM-CRC frame receiver top level: parser, command queue and result sequencer.
// Input: one beat per cycle while no good block is being written out and the queue has room.
// A good 133-byte frame yields 32 word writes, each taking one store read and one output load,
// and the output may stall them; input waits meanwhile.
// NAK and EOT replies pass through the command queue and the output register.
// Synchronous reset clears counters, CRC, block count, queue and base address; no store clear.
`include "xmodem_crc_frame_receiver_macros.svh"
module xmodem_crc_frame_receiver
  import xcrc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,   // rx_byte
  input  logic        s_tuser,   // action
  input  logic        s_tlast,   // frame_end
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [63:0] m_tdata,   // write_addr [31:0], write_word [63:32]
  output logic [3:0]  m_tuser,   // reply [1:0], write_valid [2], transfer_done [3]
  output logic        m_tlast,   // last
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [31:0] cfg_data   // base_address
);

  logic [31:0]              base_address;
  logic                     push;
  cmd_t                     push_cmd;
  logic                     q_full;
  logic                     q_empty;
  logic                     pop;
  cmd_t                     head;
  logic                     burst_done;
  logic [WORD_IDX_BITS-1:0] rd_addr;
  logic [31:0]              rd_data;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      base_address <= 32'd0;
    end else if (cfg_valid && cfg_ready) begin
      base_address <= cfg_data;
    end
  end

  xcrc_front u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .s_tlast    (s_tlast),
    .push       (push),
    .cmd        (push_cmd),
    .q_full     (q_full),
    .burst_done (burst_done),
    .rd_addr    (rd_addr),
    .rd_data    (rd_data)
  );

  xcrc_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .full     (q_full),
    .pop      (pop),
    .empty    (q_empty),
    .head     (head)
  );

  xcrc_back u_back (
    .clk          (clk),
    .rst          (rst),
    .base_address (base_address),
    .empty        (q_empty),
    .head         (head),
    .pop          (pop),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .burst_done   (burst_done),
    .m_tvalid     (m_tvalid),
    .m_tready     (m_tready),
    .m_tdata      (m_tdata),
    .m_tuser      (m_tuser),
    .m_tlast      (m_tlast)
  );

  `XCRC_ASSERT_NOW(a_no_overflow, push, !q_full, "command pushed into a full queue")
  `XCRC_ASSERT_NOW(a_mid_burst, m_tvalid && !m_tlast,
                   m_tuser[2] && m_tuser[1:0] == REPLY_NONE && !m_tuser[3],
                   "non-final beat is not a plain word write")
  `XCRC_ASSERT_NOW(a_done_reply, m_tvalid && m_tuser[3],
                   m_tlast && !m_tuser[2] && m_tuser[1:0] == REPLY_ACK,
                   "transfer done without a lone ACK")
  `XCRC_ASSERT_NEXT(a_burst_locks_input, push && push_cmd.kind == CMD_BURST,
                    !s_tready, "input taken while a block is being written out")

endmodule

/* hdl/xcrc_queue.sv */
// Two-entry command queue between the frame parser and the result sequencer.
module xcrc_queue
  import xcrc_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output logic empty,
  output cmd_t head
);

  cmd_t       entry [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;

  assign full  = (count == 2'd2);
  assign empty = (count == 2'd0);
  assign head  = entry[rd_ptr];

  always_ff @(posedge clk) begin
    if (push && !full) begin
      entry[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push && !full) begin
        wr_ptr <= ~wr_ptr;
      end
      if (pop && !empty) begin
        rd_ptr <= ~rd_ptr;
      end
      case ({push && !full, pop && !empty})
        2'b10:   count <= count + 2'd1;
        2'b01:   count <= count - 2'd1;
        default: count <= count;
      endcase
    end
  end

endmodule

/* hdl/xcrc_front.sv */
// Frame parser: takes input beats, checks the CRC, stores the data bytes and issues commands.
module xcrc_front
  import xcrc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  input  logic [7:0]               s_tdata,   // rx_byte
  input  logic                     s_tuser,   // action
  input  logic                     s_tlast,   // frame_end
  output logic                     push,
  output cmd_t                     cmd,
  input  logic                     q_full,
  input  logic                     burst_done,
  input  logic [WORD_IDX_BITS-1:0] rd_addr,
  output logic [31:0]              rd_data
);

  logic [7:0]                  byte_count, byte_count_next;
  logic [15:0]                 crc_accum, crc_accum_next;
  logic [7:0]                  lead_byte, lead_byte_next;
  logic [15:0]                 rx_crc, rx_crc_next;
  logic [BLOCK_COUNT_BITS-1:0] block_count, block_count_next;
  logic                        burst_pending, burst_pending_next;
  logic [31:0]                 mem [WORDS];

  logic       accept;
  logic       in_data;
  logic [7:0] data_off;
  logic [7:0] len;

  // The store holds the frame being sent out until its last word has left.
  assign s_tready = !q_full && !burst_pending;
  assign accept   = s_tvalid && s_tready;
  assign in_data  = (byte_count >= DATA_FIRST) && (byte_count < CRC_HI_IDX);
  assign data_off = byte_count - DATA_FIRST;
  assign len      = (byte_count < LEN_SAT) ? byte_count + 8'd1 : LEN_SAT;

  always_comb begin
    byte_count_next    = byte_count;
    crc_accum_next     = crc_accum;
    lead_byte_next     = lead_byte;
    rx_crc_next        = rx_crc;
    block_count_next   = block_count;
    burst_pending_next = burst_pending && !burst_done;
    push               = 1'b0;
    cmd.kind           = CMD_NAK;
    cmd.blk            = block_count;
    if (accept) begin
      if (s_tuser) begin
        block_count_next = '0;
        byte_count_next  = 8'd0;
        crc_accum_next   = CRC_INIT;
        lead_byte_next   = 8'd0;
        rx_crc_next      = 16'd0;
      end else begin
        if (byte_count == 8'd0) begin
          lead_byte_next = s_tdata;
        end else if (in_data) begin
          crc_accum_next = crc_byte(crc_accum, s_tdata);
        end else if (byte_count == CRC_HI_IDX) begin
          rx_crc_next = {s_tdata, rx_crc[7:0]};
        end else if (byte_count == CRC_LO_IDX) begin
          rx_crc_next = {rx_crc[15:8], s_tdata};
        end
        byte_count_next = len;
        if (s_tlast) begin
          if (len == FRAME_LEN && lead_byte == LEAD_SOH) begin
            push = 1'b1;
            // The low CRC byte arrives on this very beat.
            if (crc_accum == {rx_crc[15:8], s_tdata} && block_count != '1) begin
              cmd.kind           = CMD_BURST;
              block_count_next   = block_count + 1'b1;
              burst_pending_next = 1'b1;
            end
          end else if (len == 8'd1 && s_tdata == LEAD_EOT) begin
            push     = 1'b1;
            cmd.kind = CMD_EOT;
          end
          byte_count_next = 8'd0;
          crc_accum_next  = CRC_INIT;
          lead_byte_next  = 8'd0;
          rx_crc_next     = 16'd0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count    <= 8'd0;
      crc_accum     <= CRC_INIT;
      lead_byte     <= 8'd0;
      rx_crc        <= 16'd0;
      block_count   <= '0;
      burst_pending <= 1'b0;
    end else begin
      byte_count    <= byte_count_next;
      crc_accum     <= crc_accum_next;
      lead_byte     <= lead_byte_next;
      rx_crc        <= rx_crc_next;
      block_count   <= block_count_next;
      burst_pending <= burst_pending_next;
    end
  end

  // Word-wide store with one byte lane written per data beat.
  always_ff @(posedge clk) begin
    if (accept && !s_tuser && in_data) begin
      mem[data_off[WORD_IDX_BITS+1:2]][data_off[1:0]*8 +: 8] <= s_tdata;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

/* hdl/xcrc_back.sv */
// Result sequencer: turns commands into reply and word-write beats on the output stream.
module xcrc_back
  import xcrc_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic [31:0]              base_address,
  input  logic                     empty,
  input  cmd_t                     head,
  output logic                     pop,
  output logic [WORD_IDX_BITS-1:0] rd_addr,
  input  logic [31:0]              rd_data,
  output logic                     burst_done,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  output logic [63:0]              m_tdata,   // write_addr, write_word
  output logic [3:0]               m_tuser,   // reply[1:0], write_valid, transfer_done
  output logic                     m_tlast    // last
);

  back_state_t              state, state_next;
  logic [WORD_IDX_BITS-1:0] word_idx, word_idx_next;
  logic [31:0]              addr, addr_next;

  logic        slot_free;
  logic        load;
  logic [63:0] load_data;
  logic [3:0]  load_user;
  logic        load_last;
  logic        last_word;

  assign slot_free = !m_tvalid || m_tready;
  assign rd_addr   = word_idx;
  assign last_word = (word_idx == WORD_IDX_BITS'(WORDS - 1));

  always_comb begin
    state_next    = state;
    word_idx_next = word_idx;
    addr_next     = addr;
    pop           = 1'b0;
    burst_done    = 1'b0;
    load          = 1'b0;
    load_data     = 64'd0;
    load_user     = {1'b0, 1'b0, REPLY_NONE};
    load_last     = 1'b0;
    unique case (state)
      BK_IDLE: begin
        if (!empty && slot_free) begin
          pop = 1'b1;
          unique case (head.kind)
            CMD_BURST: begin
              addr_next     = base_address + 32'({head.blk, 7'b0000000});
              word_idx_next = '0;
              state_next    = BK_FETCH;
            end
            CMD_NAK: begin
              load      = 1'b1;
              load_user = {1'b0, 1'b0, REPLY_NAK};
              load_last = 1'b1;
            end
            CMD_EOT: begin
              load      = 1'b1;
              load_user = {1'b1, 1'b0, REPLY_ACK};
              load_last = 1'b1;
            end
            default: ;
          endcase
        end
      end
      BK_FETCH: begin
        // Store read data is registered and shows up in the cycle after the address.
        state_next = BK_EMIT;
      end
      BK_EMIT: begin
        if (slot_free) begin
          load      = 1'b1;
          load_data = {rd_data, addr};
          load_user = {1'b0, 1'b1, last_word ? REPLY_ACK : REPLY_NONE};
          load_last = last_word;
          if (last_word) begin
            burst_done = 1'b1;
            state_next = BK_IDLE;
          end else begin
            word_idx_next = word_idx + 1'b1;
            addr_next     = addr + 32'd4;
            state_next    = BK_FETCH;
          end
        end
      end
      default: state_next = BK_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= BK_IDLE;
      word_idx <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      word_idx <= word_idx_next;
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    addr <= addr_next;
    if (load) begin
      m_tdata <= load_data;
      m_tuser <= load_user;
      m_tlast <= load_last;
    end
  end

endmodule
